@@ rtl/srt_pkg.sv @@
// shared types and constants for the sorted record table
// no dependencies
`default_nettype none

package srt_pkg;

   localparam int DEPTH_DEF = 64;

   localparam int OP_W     = 3;
   localparam int CODE_W   = 40;
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int DATE_W   = YEAR_W + MONTH_W + DAY_W;
   localparam int POSTAL_W = 17;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_FIND   = 3'd1,
      OP_REMOVE = 3'd2,
      OP_RANGE  = 3'd3,
      OP_DUMP   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_NONE  = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // date packed as year, month, day so that it compares as a plain number
   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic [DATE_W-1:0]   date;
      logic [POSTAL_W-1:0] postal;
      logic [HANDLE_W-1:0] handle;
   } rec_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_INS,
      S_PLACE0,
      S_SCAN,
      S_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      POS_HOLD,
      POS_ZERO,
      POS_INC,
      POS_DEC,
      POS_TOP
   } pos_op_type;

   typedef enum logic [1:0] {
      EMIT_STATUS,
      EMIT_NEW,
      EMIT_PEND
   } emit_type;

   typedef enum logic {
      PLACE_NEXT,
      PLACE_ZERO
   } place_type;

   typedef struct packed {
      logic       load;
      pos_op_type pos_op;
      logic       head_cap;
      logic       ins_move;
      logic       ins_place;
      place_type  place_sel;
      logic       scan_init;
      logic       scan_step;
      logic       scan_finish;
      logic       emit;
      emit_type   emit_sel;
      status_type status;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   rsp_free;
      logic   count_zero;
      logic   count_full;
      logic   range_bad;
      logic   move;
      logic   pos_zero;
      logic   at_end;
      logic   pend_valid;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/srt_ctrl.sv @@
// sequencer for the sorted record table
// depends on srt_pkg
`default_nettype none

module srt_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  srt_pkg::sts_type     sts,
   output srt_pkg::cmd_type     cmd
);

   srt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.pos_op    = srt_pkg::POS_HOLD;
      cmd.place_sel = srt_pkg::PLACE_NEXT;
      cmd.emit_sel  = srt_pkg::EMIT_STATUS;
      cmd.status    = srt_pkg::ST_OK;
      case (state_ff)
         srt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               cmd.pos_op = srt_pkg::POS_ZERO;
               state_in   = srt_pkg::S_DECODE;
            end
         end
         srt_pkg::S_DECODE: begin
            case (sts.op)
               srt_pkg::OP_INSERT: begin
                  if (sts.count_full) begin
                     if (sts.rsp_free) begin
                        cmd.emit   = 1'b1;
                        cmd.status = srt_pkg::ST_FULL;
                        state_in   = srt_pkg::S_IDLE;
                     end
                  end else if (sts.count_zero) begin
                     if (sts.rsp_free) begin
                        cmd.ins_place = 1'b1;
                        cmd.place_sel = srt_pkg::PLACE_ZERO;
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = srt_pkg::EMIT_NEW;
                        state_in      = srt_pkg::S_IDLE;
                     end
                  end else begin
                     cmd.head_cap = 1'b1;
                     cmd.pos_op   = srt_pkg::POS_TOP;
                     state_in     = srt_pkg::S_INS;
                  end
               end
               srt_pkg::OP_FIND, srt_pkg::OP_REMOVE, srt_pkg::OP_DUMP: begin
                  cmd.scan_init = 1'b1;
                  state_in      = srt_pkg::S_SCAN;
               end
               srt_pkg::OP_RANGE: begin
                  if (sts.range_bad) begin
                     if (sts.rsp_free) begin
                        cmd.emit   = 1'b1;
                        cmd.status = srt_pkg::ST_RANGE;
                        state_in   = srt_pkg::S_IDLE;
                     end
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = srt_pkg::S_SCAN;
                  end
               end
               default: begin
                  state_in = srt_pkg::S_IDLE;
               end
            endcase
         end
         srt_pkg::S_INS: begin
            if (sts.rsp_free) begin
               if (sts.move) begin
                  cmd.ins_move = 1'b1;
                  if (sts.pos_zero) begin
                     state_in = srt_pkg::S_PLACE0;
                  end else begin
                     cmd.pos_op = srt_pkg::POS_DEC;
                  end
               end else begin
                  cmd.ins_place = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = srt_pkg::EMIT_NEW;
                  state_in      = srt_pkg::S_IDLE;
               end
            end
         end
         srt_pkg::S_PLACE0: begin
            if (sts.rsp_free) begin
               cmd.ins_place = 1'b1;
               cmd.place_sel = srt_pkg::PLACE_ZERO;
               cmd.emit      = 1'b1;
               cmd.emit_sel  = srt_pkg::EMIT_NEW;
               state_in      = srt_pkg::S_IDLE;
            end
         end
         srt_pkg::S_SCAN: begin
            if (sts.at_end) begin
               cmd.scan_finish = 1'b1;
               state_in        = srt_pkg::S_FLUSH;
            end else if (sts.rsp_free) begin
               cmd.scan_step = 1'b1;
               cmd.pos_op    = srt_pkg::POS_INC;
            end
         end
         srt_pkg::S_FLUSH: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               if (sts.pend_valid) begin
                  cmd.emit_sel = srt_pkg::EMIT_PEND;
               end else begin
                  cmd.status = srt_pkg::ST_NONE;
               end
               state_in = srt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = srt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/srt_dp.sv @@
// datapath of the sorted record table: record memory, pointers, result register
// depends on srt_pkg
`default_nettype none

module srt_dp #(
   parameter int DEPTH = srt_pkg::DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [srt_pkg::OP_W-1:0]      req_operation,
   input  wire logic [srt_pkg::CODE_W-1:0]    req_code,
   input  wire logic [srt_pkg::DAY_W-1:0]     req_day,
   input  wire logic [srt_pkg::MONTH_W-1:0]   req_month,
   input  wire logic [srt_pkg::YEAR_W-1:0]    req_year,
   input  wire logic [srt_pkg::DAY_W-1:0]     req_upper_day,
   input  wire logic [srt_pkg::MONTH_W-1:0]   req_upper_month,
   input  wire logic [srt_pkg::YEAR_W-1:0]    req_upper_year,
   input  wire logic [srt_pkg::POSTAL_W-1:0]  req_postal_code,
   input  wire logic [srt_pkg::HANDLE_W-1:0]  req_record_handle,
   input  srt_pkg::cmd_type                   cmd,
   output srt_pkg::sts_type                   sts,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [srt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [srt_pkg::CODE_W-1:0]         rsp_found_code,
   output logic [srt_pkg::DAY_W-1:0]          rsp_found_day,
   output logic [srt_pkg::MONTH_W-1:0]        rsp_found_month,
   output logic [srt_pkg::YEAR_W-1:0]         rsp_found_year,
   output logic [srt_pkg::POSTAL_W-1:0]       rsp_found_postal,
   output logic [srt_pkg::HANDLE_W-1:0]       rsp_found_handle,
   output logic                               rsp_last
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   srt_pkg::rec_type mem [DEPTH];

   srt_pkg::op_type                   op_ff;
   logic [srt_pkg::CODE_W-1:0]        key_ff;
   logic [srt_pkg::DATE_W-1:0]        lo_ff, up_ff;
   logic [srt_pkg::POSTAL_W-1:0]      postal_ff;
   logic [srt_pkg::HANDLE_W-1:0]      handle_ff;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  pos_ff, pos_in, pos_nx;
   logic [CNT_W-1:0]                  wp_ff, wp_in;
   logic                              head_le_ff;
   logic                              hit_seen_ff, hit_seen_in;
   srt_pkg::rec_type                  rd_ff;
   srt_pkg::rec_type                  pend_ff, pend_in;
   logic                              pend_valid_ff, pend_valid_in;
   srt_pkg::rec_type                  new_rec;
   logic                              hit, removes, keep, push;
   logic                              wr_en;
   logic [IDX_W-1:0]                  wr_addr;
   srt_pkg::rec_type                  wr_data;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [srt_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   srt_pkg::rec_type                  rsp_rec_ff, rsp_rec_in;
   logic                              rsp_last_ff, rsp_last_in;

   assign new_rec = '{code: key_ff, date: lo_ff, postal: postal_ff, handle: handle_ff};
   assign pos_nx  = pos_ff + CNT_W'(1);

   always_comb begin
      case (cmd.pos_op)
         srt_pkg::POS_ZERO: pos_in = '0;
         srt_pkg::POS_INC:  pos_in = pos_nx;
         srt_pkg::POS_DEC:  pos_in = pos_ff - CNT_W'(1);
         srt_pkg::POS_TOP:  pos_in = count_ff - CNT_W'(1);
         default:           pos_in = pos_ff;
      endcase
   end

   // scan decisions on the entry in the read register
   always_comb begin
      case (op_ff)
         srt_pkg::OP_FIND, srt_pkg::OP_REMOVE: hit = (rd_ff.code == key_ff) && !hit_seen_ff;
         srt_pkg::OP_RANGE: hit = (rd_ff.date >= lo_ff) && (rd_ff.date <= up_ff);
         srt_pkg::OP_DUMP:  hit = 1'b1;
         default:           hit = 1'b0;
      endcase
   end

   assign removes = (op_ff == srt_pkg::OP_REMOVE) || (op_ff == srt_pkg::OP_RANGE);
   assign keep    = !(hit && removes);
   assign push    = cmd.scan_step && hit && pend_valid_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_nx[IDX_W-1:0];
      wr_data = rd_ff;
      if (cmd.scan_step && keep) begin
         wr_en   = 1'b1;
         wr_addr = wp_ff[IDX_W-1:0];
      end else if (cmd.ins_move) begin
         wr_en = 1'b1;
      end else if (cmd.ins_place) begin
         wr_en   = 1'b1;
         wr_data = new_rec;
         if (cmd.place_sel == srt_pkg::PLACE_ZERO) begin
            wr_addr = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[pos_in[IDX_W-1:0]];
   end

   always_comb begin
      count_in      = count_ff;
      wp_in         = wp_ff;
      hit_seen_in   = hit_seen_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.ins_place) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.scan_finish) begin
         count_in = wp_ff;
      end
      if (cmd.scan_init) begin
         wp_in         = '0;
         hit_seen_in   = 1'b0;
         pend_valid_in = 1'b0;
      end
      if (cmd.scan_step) begin
         if (keep) begin
            wp_in = wp_ff + CNT_W'(1);
         end
         if (hit) begin
            hit_seen_in   = 1'b1;
            pend_in       = rd_ff;
            pend_valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_last_in   = rsp_last_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = srt_pkg::ST_OK;
         rsp_rec_in    = pend_ff;
         rsp_last_in   = 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         case (cmd.emit_sel)
            srt_pkg::EMIT_NEW: begin
               rsp_status_in = srt_pkg::ST_OK;
               rsp_rec_in    = new_rec;
            end
            srt_pkg::EMIT_PEND: begin
               rsp_status_in = srt_pkg::ST_OK;
               rsp_rec_in    = pend_ff;
            end
            default: begin
               rsp_status_in = cmd.status;
               rsp_rec_in    = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pos_ff        <= '0;
         wp_ff         <= '0;
         hit_seen_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         wp_ff         <= wp_in;
         hit_seen_ff   <= hit_seen_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= srt_pkg::op_type'(req_operation);
         key_ff    <= req_code;
         lo_ff     <= {req_year, req_month, req_day};
         up_ff     <= {req_upper_year, req_upper_month, req_upper_day};
         postal_ff <= req_postal_code;
         handle_ff <= req_record_handle;
      end
      if (cmd.head_cap) begin
         head_le_ff <= (rd_ff.date <= lo_ff);
      end
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign sts.op         = op_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign sts.count_zero = (count_ff == '0);
   assign sts.count_full = (count_ff == CNT_W'(DEPTH));
   assign sts.range_bad  = (up_ff < lo_ff);
   assign sts.move       = head_le_ff || (rd_ff.date < lo_ff);
   assign sts.pos_zero   = (pos_ff == '0);
   assign sts.at_end     = (pos_ff == count_ff);
   assign sts.pend_valid = pend_valid_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_code   = rsp_rec_ff.code;
   assign rsp_found_day    = rsp_rec_ff.date[srt_pkg::DAY_W-1:0];
   assign rsp_found_month  = rsp_rec_ff.date[srt_pkg::DAY_W +: srt_pkg::MONTH_W];
   assign rsp_found_year   = rsp_rec_ff.date[srt_pkg::DATE_W-1 -: srt_pkg::YEAR_W];
   assign rsp_found_postal = rsp_rec_ff.postal;
   assign rsp_found_handle = rsp_rec_ff.handle;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/sorted_record_table.sv @@
// sorted record table: up to DEPTH records kept newest first in one memory
// throughput: one item at a time, set by the one-entry-per-cycle walk of the memory port
// results leave through a one-beat output register; a busy consumer stalls the walk
// reset (synchronous, active high) empties the table; record memory is not cleared
// depends on srt_pkg, srt_ctrl, srt_dp
`default_nettype none

module sorted_record_table #(
   parameter int DEPTH = srt_pkg::DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [srt_pkg::OP_W-1:0]      req_operation,
   input  wire logic [srt_pkg::CODE_W-1:0]    req_code,
   input  wire logic [srt_pkg::DAY_W-1:0]     req_day,
   input  wire logic [srt_pkg::MONTH_W-1:0]   req_month,
   input  wire logic [srt_pkg::YEAR_W-1:0]    req_year,
   input  wire logic [srt_pkg::DAY_W-1:0]     req_upper_day,
   input  wire logic [srt_pkg::MONTH_W-1:0]   req_upper_month,
   input  wire logic [srt_pkg::YEAR_W-1:0]    req_upper_year,
   input  wire logic [srt_pkg::POSTAL_W-1:0]  req_postal_code,
   input  wire logic [srt_pkg::HANDLE_W-1:0]  req_record_handle,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [srt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [srt_pkg::CODE_W-1:0]         rsp_found_code,
   output logic [srt_pkg::DAY_W-1:0]          rsp_found_day,
   output logic [srt_pkg::MONTH_W-1:0]        rsp_found_month,
   output logic [srt_pkg::YEAR_W-1:0]         rsp_found_year,
   output logic [srt_pkg::POSTAL_W-1:0]       rsp_found_postal,
   output logic [srt_pkg::HANDLE_W-1:0]       rsp_found_handle,
   output logic                               rsp_last
);

   // inserts read the head first, then shift entries down from the tail
   // until the slot for the new record opens; the other operations run one
   // compaction pass that emits hits and rewrites the kept entries in place.
   // the newest hit is held back one beat so the final beat can carry last

   srt_pkg::cmd_type cmd;
   srt_pkg::sts_type sts;

   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   srt_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_code          (req_code),
      .req_day           (req_day),
      .req_month         (req_month),
      .req_year          (req_year),
      .req_upper_day     (req_upper_day),
      .req_upper_month   (req_upper_month),
      .req_upper_year    (req_upper_year),
      .req_postal_code   (req_postal_code),
      .req_record_handle (req_record_handle),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_found_code    (rsp_found_code),
      .rsp_found_day     (rsp_found_day),
      .rsp_found_month   (rsp_found_month),
      .rsp_found_year    (rsp_found_year),
      .rsp_found_postal  (rsp_found_postal),
      .rsp_found_handle  (rsp_found_handle),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

@@ dv/srt_checker.sv @@
// checker for the sorted record table: watches both channels, keeps its own copy of the
// table, predicts every result beat and compares it field by field
// depends on srt_pkg
`default_nettype none

module srt_checker
   import srt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [OP_W-1:0]       req_operation,
   input  wire logic [CODE_W-1:0]     req_code,
   input  wire logic [DAY_W-1:0]      req_day,
   input  wire logic [MONTH_W-1:0]    req_month,
   input  wire logic [YEAR_W-1:0]     req_year,
   input  wire logic [DAY_W-1:0]      req_upper_day,
   input  wire logic [MONTH_W-1:0]    req_upper_month,
   input  wire logic [YEAR_W-1:0]     req_upper_year,
   input  wire logic [POSTAL_W-1:0]   req_postal_code,
   input  wire logic [HANDLE_W-1:0]   req_record_handle,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [STATUS_W-1:0]   rsp_status,
   input  wire logic [CODE_W-1:0]     rsp_found_code,
   input  wire logic [DAY_W-1:0]      rsp_found_day,
   input  wire logic [MONTH_W-1:0]    rsp_found_month,
   input  wire logic [YEAR_W-1:0]     rsp_found_year,
   input  wire logic [POSTAL_W-1:0]   rsp_found_postal,
   input  wire logic [HANDLE_W-1:0]   rsp_found_handle,
   input  wire logic                  rsp_last,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS = DEPTH_DEF;

   typedef struct packed {
      status_type status;
      rec_type    rec;
      logic       last;
   } beat_type;

   rec_type  table_rows [ROWS];
   int       row_count;
   beat_type due_beats [$];

   function automatic void push_beat(status_type st, rec_type r, logic lst);
      beat_type b;
      b.status = st;
      b.rec = (st == ST_OK) ? r : '0;
      b.last = lst;
      due_beats.push_back(b);
   endfunction

   function automatic void drop_row(int idx);
      for (int j = idx; j + 1 < row_count; j++) table_rows[j] = table_rows[j + 1];
      row_count--;
   endfunction

   function automatic int first_with_code(logic [CODE_W-1:0] c);
      for (int i = 0; i < row_count; i++) if (table_rows[i].code == c) return i;
      return -1;
   endfunction

   function automatic void predict(logic [OP_W-1:0] op, rec_type nr, logic [DATE_W-1:0] hi);
      int pos;
      int hits;
      case (op)
         OP_INSERT: begin
            if (row_count >= ROWS) begin
               push_beat(ST_FULL, '0, 1'b1);
            end else begin
               if (row_count == 0 || table_rows[0].date <= nr.date) begin
                  pos = 0;
               end else begin
                  pos = 1;
                  while (pos < row_count && nr.date <= table_rows[pos].date) pos++;
               end
               for (int i = row_count; i > pos; i--) table_rows[i] = table_rows[i - 1];
               table_rows[pos] = nr;
               row_count++;
               push_beat(ST_OK, nr, 1'b1);
            end
         end
         OP_FIND, OP_REMOVE: begin
            pos = first_with_code(nr.code);
            if (pos < 0) begin
               push_beat(ST_NONE, '0, 1'b1);
            end else begin
               push_beat(ST_OK, table_rows[pos], 1'b1);
               if (op == OP_REMOVE) drop_row(pos);
            end
         end
         OP_RANGE: begin
            if (hi < nr.date) begin
               push_beat(ST_RANGE, '0, 1'b1);
            end else begin
               hits = 0;
               pos = 0;
               while (pos < row_count && table_rows[pos].date >= nr.date) begin
                  if (table_rows[pos].date <= hi) begin
                     push_beat(ST_OK, table_rows[pos], 1'b0);
                     hits++;
                     drop_row(pos);
                  end else begin
                     pos++;
                  end
               end
               if (hits == 0) push_beat(ST_NONE, '0, 1'b1);
               else due_beats[due_beats.size() - 1].last = 1'b1;
            end
         end
         OP_DUMP: begin
            if (row_count == 0) push_beat(ST_NONE, '0, 1'b1);
            for (int i = 0; i < row_count; i++)
               push_beat(ST_OK, table_rows[i], i + 1 == row_count);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      beat_type got;
      beat_type want;
      rec_type  nr;
      if (reset) begin
         row_count = 0;
         due_beats.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.status = status_type'(rsp_status);
            got.rec.code = rsp_found_code;
            got.rec.date = {rsp_found_year, rsp_found_month, rsp_found_day};
            got.rec.postal = rsp_found_postal;
            got.rec.handle = rsp_found_handle;
            got.last = rsp_last;
            if (due_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("%t checker: unexpected beat %h", $realtime, got);
            end else begin
               want = due_beats.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%t checker: mismatch expected st=%0d rec=%h last=%b,",
                              $realtime, want.status, want.rec, want.last,
                              " got st=%0d rec=%h last=%b",
                              got.status, got.rec, got.last);
               end
            end
         end
         if (req_valid && req_ready) begin
            nr.code = req_code;
            nr.date = {req_year, req_month, req_day};
            nr.postal = req_postal_code;
            nr.handle = req_record_handle;
            predict(req_operation, nr, {req_upper_year, req_upper_month, req_upper_day});
         end
      end
      pending = due_beats.size();
   end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// top of the sorted record table testbench: clock, reset, stimulus and verdict
// depends on srt_pkg, sorted_record_table and srt_checker
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import srt_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = '0;
   logic [CODE_W-1:0]   req_code = '0;
   logic [DAY_W-1:0]    req_day = '0;
   logic [MONTH_W-1:0]  req_month = '0;
   logic [YEAR_W-1:0]   req_year = '0;
   logic [DAY_W-1:0]    req_upper_day = '0;
   logic [MONTH_W-1:0]  req_upper_month = '0;
   logic [YEAR_W-1:0]   req_upper_year = '0;
   logic [POSTAL_W-1:0] req_postal_code = '0;
   logic [HANDLE_W-1:0] req_record_handle = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [CODE_W-1:0]   rsp_found_code;
   logic [DAY_W-1:0]    rsp_found_day;
   logic [MONTH_W-1:0]  rsp_found_month;
   logic [YEAR_W-1:0]   rsp_found_year;
   logic [POSTAL_W-1:0] rsp_found_postal;
   logic [HANDLE_W-1:0] rsp_found_handle;
   logic                rsp_last;
   int                  fail_count;
   int                  pending;

   // no idling on either side once set, for the closing stretch of the run
   logic                quiet = 1'b0;
   int                  stall_left = 0;

   // small pool of codes so that find and remove actually hit something
   logic [CODE_W-1:0]   code_pool [4];

   always #10 clock = ~clock;

   sorted_record_table u_dut (.*);

   srt_checker u_chk (.*);

   // consumer side: random stall bursts, none when quiet
   always @(posedge clock) begin
      logic nxt;
      if (stall_left > 0) begin
         stall_left--;
         nxt = 1'b0;
      end else if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         nxt = 1'b0;
      end else begin
         nxt = 1'b1;
      end
      rsp_ready <= nxt;
   end

   // one request beat: optional gap with valid low, then hold until accepted
   task automatic send_beat(logic [OP_W-1:0] op, logic [CODE_W-1:0] c,
                            logic [DATE_W-1:0] lo, logic [DATE_W-1:0] hi,
                            logic [POSTAL_W-1:0] pc, logic [HANDLE_W-1:0] h);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_code <= c;
      {req_year, req_month, req_day} <= lo;
      {req_upper_year, req_upper_month, req_upper_day} <= hi;
      req_postal_code <= pc;
      req_record_handle <= h;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [DATE_W-1:0] make_date(int y, int m, int d);
      return {YEAR_W'(y), MONTH_W'(m), DAY_W'(d)};
   endfunction

   // mostly a narrow set of dates so ties and range hits are common
   function automatic logic [DATE_W-1:0] pick_date();
      if ($urandom_range(0, 3) == 0)
         return make_date($urandom_range(0, 9999), $urandom_range(1, 12),
                          $urandom_range(1, 31));
      return make_date($urandom_range(2000, 2002), $urandom_range(1, 3),
                       $urandom_range(1, 4));
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      if ($urandom_range(0, 2) == 0) return CODE_W'({$urandom, $urandom});
      return code_pool[$urandom_range(0, 3)];
   endfunction

   function automatic logic [POSTAL_W-1:0] pick_postal();
      return POSTAL_W'($urandom_range(0, 99999));
   endfunction

   // one random item with a given operation mix
   task automatic random_item(int insert_weight);
      logic [DATE_W-1:0] a;
      logic [DATE_W-1:0] b;
      int                pick;
      a = pick_date();
      b = pick_date();
      pick = $urandom_range(0, 99);
      if (pick < insert_weight) begin
         send_beat(OP_INSERT, pick_code(), a, b, pick_postal(), $urandom);
      end else if (pick < insert_weight + 12) begin
         send_beat(OP_FIND, pick_code(), a, b, pick_postal(), $urandom);
      end else if (pick < insert_weight + 24) begin
         send_beat(OP_REMOVE, pick_code(), a, b, pick_postal(), $urandom);
      end else if (pick < insert_weight + 38) begin
         // mostly ordered bounds, sometimes reversed for the invalid status
         if ($urandom_range(0, 4) != 0 && b < a) send_beat(OP_RANGE, pick_code(), b, a, '0, '0);
         else send_beat(OP_RANGE, pick_code(), a, b, pick_postal(), $urandom);
      end else if (pick < insert_weight + 45) begin
         send_beat(OP_DUMP, pick_code(), a, b, '0, '0);
      end else begin
         // unused operation codes are ignored by the block
         send_beat(OP_W'($urandom_range(5, 7)), pick_code(), a, b, '0, $urandom);
      end
   endtask

   initial begin
      logic [DATE_W-1:0] d_mid;
      logic [CODE_W-1:0] ones;
      ones = '1;
      d_mid = make_date(2001, 3, 5);
      code_pool[0] = 40'h4142434445;
      code_pool[1] = 40'h5A5A5A5A5A;
      code_pool[2] = 40'h3031323334;
      code_pool[3] = ones;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-table cases first
      send_beat(OP_DUMP, '0, '0, '0, '0, '0);
      send_beat(OP_FIND, ones, d_mid, d_mid, '0, '0);
      send_beat(OP_REMOVE, ones, d_mid, d_mid, '0, '0);
      send_beat(OP_RANGE, '0, d_mid, make_date(2001, 3, 4), '0, '0);   // upper before lower
      send_beat(OP_RANGE, '0, make_date(0, 1, 1), make_date(9999, 12, 31), '0, '0);
      // field extremes and tie placement
      send_beat(OP_INSERT, ones, d_mid, '0, 17'd99999, 32'hFFFF_FFFF);
      send_beat(OP_INSERT, code_pool[0], d_mid, '0, 17'd1, 32'h1);        // ties head
      send_beat(OP_INSERT, '0, make_date(0, 1, 1), '0, '0, '0);
      send_beat(OP_INSERT, code_pool[1], make_date(0, 1, 1), '0, 17'd2, 32'h2);
      send_beat(OP_INSERT, code_pool[2], make_date(9999, 12, 31), '0, 17'd3, 32'h3);
      send_beat(OP_INSERT, ones, d_mid, '0, 17'd65535, 32'h5555_AAAA);   // tie below head
      send_beat(OP_FIND, ones, '0, '0, '0, '0);
      send_beat(OP_REMOVE, ones, '0, '0, '0, '0);
      send_beat(OP_FIND, ones, '0, '0, '0, '0);
      send_beat(OP_FIND, 40'h1234567890, '0, '0, '0, '0);
      send_beat(OP_DUMP, '0, '0, '0, '0, '0);
      send_beat(OP_RANGE, '0, d_mid, d_mid, '0, '0);                     // equal bounds
      send_beat(OP_RANGE, '0, make_date(2500, 1, 1), make_date(2600, 1, 1), '0, '0);
      send_beat(OP_RANGE, '0, make_date(0, 1, 1), make_date(9999, 12, 31), '0, '0);
      send_beat(OP_DUMP, '0, '0, '0, '0, '0);
      send_beat(3'd5, ones, '0, '0, '0, '0);
      send_beat(3'd6, '0, '0, '0, '0, '0);
      send_beat(3'd7, ones, '1, '1, '1, '1);

      // fill past capacity so the full status and the longest dump are seen
      repeat (70) send_beat(OP_INSERT, pick_code(), pick_date(), '0,
                            pick_postal(), $urandom);
      send_beat(OP_DUMP, '0, '0, '0, '0, '0);

      // mixed traffic, inserts weighted so the table keeps a useful size
      repeat (130) random_item(45);

      // closing stretch with no idling on either side
      quiet <= 1'b1;
      repeat (40) random_item(45);
      req_valid <= 1'b0;

      // drain, then wait a while for anything stray
      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

@@ sorted_record_table.f @@
rtl/srt_pkg.sv
rtl/srt_ctrl.sv
rtl/srt_dp.sv
rtl/sorted_record_table.sv
dv/srt_checker.sv
dv/tb.sv
